@@ rtl/csd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk stream deframer package
// Shared beat types, register indexes, status codes and queue sizing.
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_MSG_TYPE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BUF_TYPE = 2'd1;

  localparam logic [31:0] MSG_TYPE_RESET = 32'd0;
  localparam logic [31:0] BUF_TYPE_RESET = 32'd1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_DUP_MSG  = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  localparam logic KIND_MSG = 1'b0;
  localparam logic KIND_BUF = 1'b1;

  localparam logic [2:0] HDR_LAST_BYTE = 3'd7;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_PAYLOAD = 4'b0010,
    PH_PAD     = 4'b0100,
    PH_DRAIN   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       message_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        payload_last;
    logic        header_done;
    logic        chunk_kind;
    logic [31:0] chunk_length;
    logic        message_done;
    logic [1:0]  status;
  } out_beat_t;

endpackage
`default_nettype wire

@@ rtl/csd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk stream deframer front end
// Accepts message bytes, tracks header/payload/pad framing and builds one
// result beat per byte. Holds the chunk type registers.
// ----------------------------------------------------------------------------
module csd_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire csd_pkg::in_beat_t          in_data_i,
  input  wire logic                       full_i,
  output csd_pkg::out_beat_t              beat_o,
  output logic                            push_o,
  input  wire logic                       cfg_valid_i,
  input  wire logic [csd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                cfg_data_i
);

  csd_pkg::phase_e ph_q, ph_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [63:0] shift_q, shift_d;
  logic [31:0] rem_q, rem_d;
  logic [1:0]  pad_q, pad_d;
  logic        seen_q, seen_d;
  logic        kind_q, kind_d;
  logic [1:0]  err_q, err_d;
  logic [31:0] msg_type_q, buf_type_q;
  logic [63:0] hdr_word;

  assign push_o   = in_valid_i && !full_i;
  assign hdr_word = {in_data_i.in_byte, shift_q[63:8]};

  always_comb begin
    logic ok;
    ok      = 1'b1;
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    pad_d   = pad_q;
    seen_d  = seen_q;
    kind_d  = kind_q;
    err_d   = err_q;
    beat_o  = '0;

    case (ph_q)
      csd_pkg::PH_HEADER: begin
        shift_d = hdr_word;
        if (cnt_q == csd_pkg::HDR_LAST_BYTE) begin
          cnt_d   = 3'd0;
          shift_d = '0;
          if (hdr_word[31:0] == msg_type_q) begin
            if (seen_q) begin
              ok   = 1'b0;
              ph_d = csd_pkg::PH_DRAIN;
              if (err_q == csd_pkg::ST_OK) err_d = csd_pkg::ST_DUP_MSG;
            end else begin
              seen_d = 1'b1;
              kind_d = csd_pkg::KIND_MSG;
            end
          end else if (hdr_word[31:0] == buf_type_q) begin
            kind_d = csd_pkg::KIND_BUF;
          end else begin
            ok   = 1'b0;
            ph_d = csd_pkg::PH_DRAIN;
            if (err_q == csd_pkg::ST_OK) err_d = csd_pkg::ST_BAD_TYPE;
          end
          if (ok) begin
            beat_o.header_done  = 1'b1;
            beat_o.chunk_kind   = kind_d;
            beat_o.chunk_length = hdr_word[63:32];
            rem_d = hdr_word[63:32];
            pad_d = 2'd0 - hdr_word[33:32];
            ph_d  = (hdr_word[63:32] != 32'd0) ? csd_pkg::PH_PAYLOAD : csd_pkg::PH_HEADER;
          end
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      csd_pkg::PH_PAYLOAD: begin
        beat_o.payload_byte  = in_data_i.in_byte;
        beat_o.payload_valid = 1'b1;
        beat_o.chunk_kind    = kind_q;
        rem_d = rem_q - 32'd1;
        if (rem_q == 32'd1) begin
          beat_o.payload_last = 1'b1;
          ph_d = (pad_q != 2'd0) ? csd_pkg::PH_PAD : csd_pkg::PH_HEADER;
        end
      end
      csd_pkg::PH_PAD: begin
        pad_d = pad_q - 2'd1;
        if (pad_q == 2'd1) ph_d = csd_pkg::PH_HEADER;
      end
      csd_pkg::PH_DRAIN: begin
        ph_d = csd_pkg::PH_DRAIN;
      end
      default: begin
        ph_d = csd_pkg::PH_HEADER;
      end
    endcase

    if (in_data_i.message_end) begin
      beat_o.message_done = 1'b1;
      if (err_d == csd_pkg::ST_OK &&
          !(ph_d == csd_pkg::PH_HEADER && cnt_d == 3'd0)) begin
        err_d = csd_pkg::ST_TRUNC;
      end
    end
    beat_o.status = err_d;

    // drop all per-message state at the end of a message
    if (in_data_i.message_end) begin
      ph_d    = csd_pkg::PH_HEADER;
      cnt_d   = 3'd0;
      shift_d = '0;
      rem_d   = '0;
      pad_d   = 2'd0;
      seen_d  = 1'b0;
      kind_d  = 1'b0;
      err_d   = csd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= csd_pkg::PH_HEADER;
      cnt_q   <= 3'd0;
      shift_q <= '0;
      rem_q   <= '0;
      pad_q   <= 2'd0;
      seen_q  <= 1'b0;
      kind_q  <= 1'b0;
      err_q   <= csd_pkg::ST_OK;
    end else if (push_o) begin
      ph_q    <= ph_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      rem_q   <= rem_d;
      pad_q   <= pad_d;
      seen_q  <= seen_d;
      kind_q  <= kind_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_type_q <= csd_pkg::MSG_TYPE_RESET;
      buf_type_q <= csd_pkg::BUF_TYPE_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == csd_pkg::CFG_MSG_TYPE) msg_type_q <= cfg_data_i;
      if (cfg_index_i == csd_pkg::CFG_BUF_TYPE) buf_type_q <= cfg_data_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/csd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk stream deframer result queue
// Short FIFO between the parser and the output side; presents the head beat.
// ----------------------------------------------------------------------------
module csd_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire csd_pkg::out_beat_t push_data_i,
  output logic                    full_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output csd_pkg::out_beat_t      out_data_o
);

  csd_pkg::out_beat_t mem_q [csd_pkg::QueueDepth];
  logic [csd_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [csd_pkg::QueueCntW-1:0] cnt_q;
  logic pop;

  assign full_o      = (cnt_q == csd_pkg::QueueCntW'(csd_pkg::QueueDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + csd_pkg::QueuePtrW'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + csd_pkg::QueuePtrW'(1);
      if (push_i && !pop) begin
        cnt_q <= cnt_q + csd_pkg::QueueCntW'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - csd_pkg::QueueCntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/chunk_stream_deframer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk stream deframer
// Splits a byte stream of type/length/payload/pad chunks into header and
// payload reports with sticky error status.
// ----------------------------------------------------------------------------
// One byte is taken per clock while in_stall_o is low and gives one result
// beat, which reaches the output in order. A four-beat queue sits between
// the parser and the output, so input keeps flowing at one byte per cycle
// while the output is briefly stalled; in_stall_o rises only when the queue is
// full. The configuration port is always ready; write the type registers only
// while no message byte is in flight.
// ----------------------------------------------------------------------------
module chunk_stream_deframer_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire csd_pkg::in_beat_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output csd_pkg::out_beat_t               out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [csd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                 cfg_data_i
);

  csd_pkg::out_beat_t beat;
  logic push, full;

  assign in_stall_o  = full;
  assign cfg_ready_o = 1'b1;

  csd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .beat_o      (beat),
    .push_o      (push),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  csd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (beat),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

@@ rtl/csd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk stream deframer port checker
// Watches the top level ports for framing and handshake consistency.
// ----------------------------------------------------------------------------
module csd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire csd_pkg::out_beat_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_last_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.payload_last |-> out_data_o.payload_valid)
    else $error("payload_last without payload_valid");

  a_header_not_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.header_done |-> !out_data_o.payload_valid)
    else $error("header_done and payload_valid on one beat");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.payload_valid && !out_data_o.message_done
      |-> out_data_o.status == csd_pkg::ST_OK)
    else $error("payload beat while an error is stored");

endmodule

bind chunk_stream_deframer_top csd_checker u_csd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
